// ===== hdl/sliding_median_filter_macros.svh =====
// Assertion macros used by the top-level sliding median filter RTL.
`ifndef SLIDING_MEDIAN_FILTER_MACROS_SVH
`define SLIDING_MEDIAN_FILTER_MACROS_SVH

// Same-cycle implication, checked on clk_i, off while rst_ni is low.
`define SMF_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk_i, off while rst_ni is low.
`define SMF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/smf_pkg.sv =====
// Package for the sliding median filter: sizes, types and shared helpers.
package smf_pkg;

  localparam int MAX_WINDOW   = 5;
  localparam int SAMPLE_WIDTH = 16;
  localparam int CFG_W        = 3;
  localparam int CNT_W        = $clog2(MAX_WINDOW + 1);

  // Work entry that meets the comparator: the one rotating into place next
  localparam int IDX_NEXT     = (MAX_WINDOW > 1) ? 1 : 0;

  typedef logic signed [SAMPLE_WIDTH-1:0]          sample_t;
  typedef logic [MAX_WINDOW-1:0][SAMPLE_WIDTH-1:0] sample_vec_t;
  typedef logic [CNT_W-1:0]                        cnt_t;
  typedef logic [CFG_W-1:0]                        cfg_t;

  localparam cfg_t WINDOW_RESET = cfg_t'(5);
  localparam cnt_t CNT_ONE      = cnt_t'(1);
  localparam cnt_t CNT_MAX      = cnt_t'(MAX_WINDOW);

  // Sequencer commands to the rank unit
  typedef struct packed {
    logic load;  // take a fresh copy of the history
    logic pick;  // start a pass: new candidate, reset rank counters
    logic cmp;   // one compare step and rotate
    logic eval;  // check finished pass against the middle ranks
  } rank_ctrl_t;

  // Window register to effective window: zero acts as one, saturate at max
  function automatic cnt_t clamp_window(cfg_t w);
    cnt_t res;
    if (w == '0) begin
      res = CNT_ONE;
    end else if (32'(w) > MAX_WINDOW) begin
      res = CNT_MAX;
    end else begin
      res = cnt_t'(w);
    end
    return res;
  endfunction

endpackage

// ===== hdl/smf_history.sv =====
// Sample history shift register and saturating fill count.
module smf_history (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  smf_pkg::sample_t     sample_i,
  output smf_pkg::sample_vec_t hist_o,
  output smf_pkg::cnt_t        fill_next_o
);

  smf_pkg::sample_vec_t hist_q, hist_d;
  smf_pkg::cnt_t        fill_q, fill_d;

  // Count that the fill will reach with the beat now being pushed
  assign fill_next_o = (fill_q < smf_pkg::CNT_MAX) ? fill_q + smf_pkg::CNT_ONE : fill_q;

  // Newest sample goes in entry 0, the rest move one place older
  always_comb begin
    hist_d = hist_q;
    fill_d = fill_q;
    if (push_i) begin
      hist_d[0] = sample_i;
      for (int i = 1; i < smf_pkg::MAX_WINDOW; i++) begin
        hist_d[i] = hist_q[i-1];
      end
      fill_d = fill_next_o;
    end
  end

  // Payload: no reset needed
  always_ff @(posedge clk_i) begin
    hist_q <= hist_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  assign hist_o = hist_q;

endmodule

// ===== hdl/smf_rank.sv =====
// Rank unit: one shared signed comparator ranks each candidate against a rotating copy.
module smf_rank (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  smf_pkg::rank_ctrl_t  ctrl_i,
  input  smf_pkg::sample_vec_t hist_i,
  input  smf_pkg::cnt_t        count_i,
  output smf_pkg::sample_t     median_o
);

  smf_pkg::sample_vec_t work_q, work_d, work_rot;
  smf_pkg::sample_t     cand_q, cand_d;
  smf_pkg::sample_t     lo_q, lo_d, hi_q, hi_d;
  smf_pkg::cnt_t        lt_q, lt_d, le_q, le_d;
  smf_pkg::cnt_t        lo_rank, hi_rank;
  logic                 cmp_lt, cmp_eq;
  logic                 match_lo, match_hi;
  logic signed [smf_pkg::SAMPLE_WIDTH:0] sum, sum_half;

  // Shared comparator: entry about to rotate into place vs. candidate
  assign cmp_lt = $signed(work_q[smf_pkg::IDX_NEXT]) < cand_q;
  assign cmp_eq = work_q[smf_pkg::IDX_NEXT] == cand_q;

  // Rotate the first count entries down by one, head wraps to the tail
  always_comb begin
    for (int i = 0; i < smf_pkg::MAX_WINDOW; i++) begin
      if (smf_pkg::cnt_t'(i + 1) == count_i) begin
        work_rot[i] = work_q[0];
      end else begin
        work_rot[i] = work_q[(i + 1) % smf_pkg::MAX_WINDOW];
      end
    end
  end

  // Middle ranks; equal for odd counts
  assign lo_rank = smf_pkg::cnt_t'((count_i - smf_pkg::CNT_ONE) >> 1);
  assign hi_rank = smf_pkg::cnt_t'(count_i >> 1);

  // Candidate holds sorted rank r when lt <= r < le
  assign match_lo = ctrl_i.eval && (lt_q <= lo_rank) && (lo_rank < le_q);
  assign match_hi = ctrl_i.eval && (lt_q <= hi_rank) && (hi_rank < le_q);

  always_comb begin
    work_d = work_q;
    cand_d = cand_q;
    lt_d   = lt_q;
    le_d   = le_q;
    lo_d   = match_lo ? cand_q : lo_q;
    hi_d   = match_hi ? cand_q : hi_q;
    if (ctrl_i.pick) begin
      // Candidate counts itself as equal
      cand_d = ctrl_i.load ? smf_pkg::sample_t'(hist_i[0]) : smf_pkg::sample_t'(work_q[0]);
      lt_d   = '0;
      le_d   = smf_pkg::CNT_ONE;
      if (ctrl_i.load) begin
        work_d = hist_i;
      end
    end else if (ctrl_i.cmp) begin
      work_d = work_rot;
      lt_d   = lt_q + smf_pkg::cnt_t'(cmp_lt);
      le_d   = le_q + smf_pkg::cnt_t'(cmp_lt | cmp_eq);
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    cand_q <= cand_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lt_q <= '0;
      le_q <= smf_pkg::CNT_ONE;
    end else begin
      lt_q <= lt_d;
      le_q <= le_d;
    end
  end

  // Floor of the mean of the two middle values (same value for odd counts)
  assign sum      = {lo_d[smf_pkg::SAMPLE_WIDTH-1], lo_d} + {hi_d[smf_pkg::SAMPLE_WIDTH-1], hi_d};
  assign sum_half = sum >>> 1;
  assign median_o = smf_pkg::sample_t'(sum_half[smf_pkg::SAMPLE_WIDTH-1:0]);

endmodule

// ===== hdl/sliding_median_filter.sv =====
// An accepted sample beat starts ranking over count samples, where
// count = min(samples received, effective window), at most 5. The single
// comparator in the rank unit does count passes, one candidate per pass; the
// block takes no new sample until the median is loaded into the output register.
// Reset: asynchronous, active low; clears fill count, sequencer and output valid,
// and sets the window length to 5.
`include "sliding_median_filter_macros.svh"

module sliding_median_filter (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 window_length_we_i,
  input  smf_pkg::cfg_t        window_length_i,
  input  logic                 sample_valid_i,
  output logic                 sample_stall_o,
  input  smf_pkg::sample_t     sample_i,
  output logic                 median_value_valid_o,
  input  logic                 median_value_stall_i,
  output smf_pkg::sample_t     median_value_o
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_PICK   = 4'b0010,
    ST_CMP    = 4'b0100,
    ST_FINISH = 4'b1000
  } state_e;

  state_e               state_q, state_d;
  smf_pkg::cfg_t        window_q;
  smf_pkg::cnt_t        count_q, count_d;
  smf_pkg::cnt_t        pass_q, pass_d;
  smf_pkg::cnt_t        step_q, step_d;
  smf_pkg::cnt_t        win_eff, fill_next, count_new;
  smf_pkg::sample_vec_t hist;
  smf_pkg::sample_t     median, median_q;
  smf_pkg::rank_ctrl_t  rank_ctrl;
  logic                 accept, out_free, out_load, out_valid_q;
  logic                 last_pass;

  // Window length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= smf_pkg::WINDOW_RESET;
    end else if (window_length_we_i) begin
      window_q <= window_length_i;
    end
  end

  assign sample_stall_o = (state_q != ST_IDLE);
  assign accept         = sample_valid_i && !sample_stall_o;

  smf_history u_history (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .sample_i    (sample_i),
    .hist_o      (hist),
    .fill_next_o (fill_next)
  );

  // Samples taken into account for this beat
  assign win_eff   = smf_pkg::clamp_window(window_q);
  assign count_new = (fill_next < win_eff) ? fill_next : win_eff;

  assign out_free  = !out_valid_q || !median_value_stall_i;
  assign out_load  = (state_q == ST_FINISH) && out_free;
  assign last_pass = (pass_q == count_q - smf_pkg::CNT_ONE);

  // Rank unit commands
  always_comb begin
    rank_ctrl.pick = (state_q == ST_PICK);
    rank_ctrl.load = (state_q == ST_PICK) && (pass_q == '0);
    rank_ctrl.cmp  = (state_q == ST_CMP);
    rank_ctrl.eval = ((state_q == ST_PICK) && (pass_q != '0)) || (state_q == ST_FINISH);
  end

  smf_rank u_rank (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (rank_ctrl),
    .hist_i   (hist),
    .count_i  (count_q),
    .median_o (median)
  );

  // Sequencer: count passes, each a pick followed by compare steps against the rest
  always_comb begin
    state_d = state_q;
    count_d = count_q;
    pass_d  = pass_q;
    step_d  = step_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          count_d = count_new;
          pass_d  = '0;
          state_d = ST_PICK;
        end
      end
      ST_PICK: begin
        step_d = smf_pkg::CNT_ONE;
        if (count_q == smf_pkg::CNT_ONE) begin
          if (last_pass) begin
            state_d = ST_FINISH;
          end else begin
            pass_d = pass_q + smf_pkg::CNT_ONE;
          end
        end else begin
          state_d = ST_CMP;
        end
      end
      ST_CMP: begin
        if (step_q == count_q - smf_pkg::CNT_ONE) begin
          if (last_pass) begin
            state_d = ST_FINISH;
          end else begin
            pass_d  = pass_q + smf_pkg::CNT_ONE;
            state_d = ST_PICK;
          end
        end else begin
          step_d = step_q + smf_pkg::CNT_ONE;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= smf_pkg::CNT_ONE;
      pass_q  <= '0;
      step_q  <= smf_pkg::CNT_ONE;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      pass_q  <= pass_d;
      step_q  <= step_d;
    end
  end

  // Output register: holds the median beat until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!median_value_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      median_q <= median;
    end
  end

  assign median_value_valid_o = out_valid_q;
  assign median_value_o       = median_q;

  `SMF_ASSERT_IMPL(a_count_range, state_q != ST_IDLE, (count_q != '0) && (count_q <= smf_pkg::CNT_MAX), "sample count out of range")
  `SMF_ASSERT_IMPL(a_pass_range, (state_q == ST_PICK) || (state_q == ST_CMP), pass_q < count_q, "pass index beyond count")
  `SMF_ASSERT_IMPL(a_step_range, state_q == ST_CMP, (step_q != '0) && (step_q < count_q), "compare step out of range")
  `SMF_ASSERT_NEXT(a_accept_start, accept, (state_q == ST_PICK) && (pass_q == '0), "accepted beat did not start ranking")
  `SMF_ASSERT_NEXT(a_finish_out, out_load, median_value_valid_o && (state_q == ST_IDLE), "finished median not presented")

endmodule

// ===== tb/sliding_median_filter_tb.sv =====
// Self-checking testbench for the sliding median filter.
module sliding_median_filter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RESET_CYCLES = 7;
  localparam int SETTLE_CYCLES = 40;    // beyond the worst sample-to-median latency
  localparam int HOLD_CYCLES = 400;     // long receiver hold-off
  localparam int IDLE_LIMIT = 3000;     // cycles without any beat before giving up
  localparam int MAX_REPORTS = 10;
  localparam int PHASE_BEATS = 65;
  localparam int NUM_PHASES = 10;

  // Expected medians plus a private copy of the filter state
  class median_scoreboard;
    smf_pkg::sample_t hist[smf_pkg::MAX_WINDOW];
    int held;
    smf_pkg::cfg_t window;
    smf_pkg::sample_t pending_medians[$];
    int failures;

    function new();
      foreach (hist[i]) hist[i] = '0;
      held = 0;
      window = smf_pkg::WINDOW_RESET;
      failures = 0;
    endfunction

    function void set_window(smf_pkg::cfg_t w);
      window = w;
    endfunction

    function int pending();
      return pending_medians.size();
    endfunction

    // Shift in the sample and return the median over the active part of the history
    function smf_pkg::sample_t median_after(smf_pkg::sample_t s);
      int vals[smf_pkg::MAX_WINDOW];
      int eff, n, i, j, t, mid;
      for (i = smf_pkg::MAX_WINDOW - 1; i > 0; i--) hist[i] = hist[i-1];
      hist[0] = s;
      if (held < smf_pkg::MAX_WINDOW) held++;
      // zero acts as one, anything past the history depth as the full depth
      if (window == 0) eff = 1;
      else if (int'(window) > smf_pkg::MAX_WINDOW) eff = smf_pkg::MAX_WINDOW;
      else eff = int'(window);
      n = (held < eff) ? held : eff;
      for (i = 0; i < n; i++) vals[i] = int'(hist[i]);
      for (i = 0; i + 1 < n; i++) begin
        for (j = i + 1; j < n; j++) begin
          if (vals[i] > vals[j]) begin
            t = vals[i];
            vals[i] = vals[j];
            vals[j] = t;
          end
        end
      end
      // even count: floor of the mean of the two middle values
      if (n % 2 == 1) mid = vals[n/2];
      else mid = (vals[n/2-1] + vals[n/2]) >>> 1;
      return smf_pkg::sample_t'(mid);
    endfunction

    function void note_sample(smf_pkg::sample_t s);
      pending_medians.push_back(median_after(s));
    endfunction

    function void fail(string msg);
      failures++;
      if (failures <= MAX_REPORTS) $display("%t ERROR: %s", $realtime, msg);
    endfunction

    function void check_median(smf_pkg::sample_t got);
      smf_pkg::sample_t want;
      if (pending_medians.size() == 0) begin
        fail($sformatf("median beat %0d with nothing expected", got));
      end else begin
        want = pending_medians.pop_front();
        if (got !== want) fail($sformatf("median expected %0d got %0d", want, got));
      end
    endfunction

    function void close_out();
      if (pending_medians.size() != 0)
        fail($sformatf("%0d medians never arrived", pending_medians.size()));
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  smf_pkg::cfg_t cfg_window = '0;
  logic sample_valid = 1'b0;
  smf_pkg::sample_t sample = '0;
  logic median_stall = 1'b0;
  logic sample_stall_o;
  logic median_valid_o;
  smf_pkg::sample_t median_o;

  median_scoreboard sb;
  smf_pkg::sample_t last_sample = '0;
  bit quiet = 1'b0;      // no gaps and no stalls while set
  bit hold_req = 1'b0;   // asks the receiver for one long hold-off
  int idle_run = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  sliding_median_filter dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_n),
    .window_length_we_i   (cfg_we),
    .window_length_i      (cfg_window),
    .sample_valid_i       (sample_valid),
    .sample_stall_o       (sample_stall_o),
    .sample_i             (sample),
    .median_value_valid_o (median_valid_o),
    .median_value_stall_i (median_stall),
    .median_value_o       (median_o)
  );

  // Gap before a sample beat: mostly none, some short, a few long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  // Random sample with a bias toward extremes, near-zero values and repeats
  function automatic smf_pkg::sample_t rand_sample();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return smf_pkg::sample_t'($urandom);
      4, 5:       return smf_pkg::sample_t'(int'($urandom_range(0, 15)) - 8);
      6: begin
        case ($urandom_range(0, 3))
          0: return smf_pkg::sample_t'(-32768);
          1: return smf_pkg::sample_t'(32767);
          2: return smf_pkg::sample_t'(0);
          default: return smf_pkg::sample_t'(-1);
        endcase
      end
      7:       return last_sample;
      8: begin
        if ($urandom_range(0, 1)) return smf_pkg::sample_t'(32767 - int'($urandom_range(0, 7)));
        return smf_pkg::sample_t'(-32768 + int'($urandom_range(0, 7)));
      end
      default: return smf_pkg::sample_t'(int'($urandom_range(0, 4000)) - 2000);
    endcase
  endfunction

  // One sample beat, optionally after some idle cycles
  task automatic push_sample(smf_pkg::sample_t s, int gap);
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    sample_valid <= 1'b1;
    sample <= s;
    @(posedge clk_i);
    while (sample_stall_o) @(posedge clk_i);
    sb.note_sample(s);
    last_sample = s;
  endtask

  // Stop sending and wait until every expected median is out, then let the block settle
  task automatic drain_medians();
    sample_valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_window(smf_pkg::cfg_t w);
    cfg_we <= 1'b1;
    cfg_window <= w;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    sb.set_window(w);
  endtask

  // Receiver: random stall runs, one long hold-off on request
  initial begin
    int n, m, r;
    forever begin
      if (hold_req) begin
        median_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (quiet) begin
        median_stall <= 1'b0;
        @(posedge clk_i);
      end else begin
        median_stall <= 1'b0;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
        repeat (n) @(posedge clk_i);
        r = $urandom_range(0, 9);
        m = (r < 5) ? 0 : (r < 9) ? $urandom_range(1, 4) : $urandom_range(10, 60);
        if (m > 0) begin
          median_stall <= 1'b1;
          repeat (m) @(posedge clk_i);
        end
      end
    end
  end

  // Median checking and watchdog
  always @(posedge clk_i) begin
    if (rst_n) begin
      if (median_valid_o && !median_stall) sb.check_median(median_o);
      if ((sample_valid && !sample_stall_o) || (median_valid_o && !median_stall)) idle_run = 0;
      else idle_run++;
      if (idle_run >= IDLE_LIMIT) begin
        $display("FAIL sliding_median_filter");
        $finish;
      end
    end
  end

  // Stimulus
  initial begin
    smf_pkg::cfg_t phase_windows[NUM_PHASES];
    int p, k;
    phase_windows = '{3'd1, 3'd3, 3'd5, 3'd2, 3'd4, 3'd6, 3'd0, 3'd7, 3'd5, 3'd3};
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // start-up fill at window 5 with the extremes, odd and even counts
    write_window(3'd5);
    push_sample(smf_pkg::sample_t'(32767), 0);
    push_sample(smf_pkg::sample_t'(-32768), 0);
    push_sample(smf_pkg::sample_t'(-32768), 1);
    push_sample(smf_pkg::sample_t'(0), 0);
    push_sample(smf_pkg::sample_t'(-1), 2);
    push_sample(smf_pkg::sample_t'(1), 0);
    push_sample(smf_pkg::sample_t'(32767), 0);
    drain_medians();

    // pairs: both maximum, both minimum, minimum against maximum
    write_window(3'd2);
    push_sample(smf_pkg::sample_t'(32767), 0);
    push_sample(smf_pkg::sample_t'(32767), 0);
    push_sample(smf_pkg::sample_t'(-32768), 0);
    push_sample(smf_pkg::sample_t'(-32768), 3);
    push_sample(smf_pkg::sample_t'(-3), 0);
    drain_medians();

    // window of zero behaves as one
    write_window(3'd0);
    push_sample(smf_pkg::sample_t'(12345), 0);
    push_sample(smf_pkg::sample_t'(-1), 0);
    drain_medians();

    // window past the history depth behaves as the full depth
    write_window(3'd7);
    push_sample(smf_pkg::sample_t'(-5), 0);
    push_sample(smf_pkg::sample_t'(100), 0);
    push_sample(smf_pkg::sample_t'(-32768), 0);
    push_sample(smf_pkg::sample_t'(7), 0);
    drain_medians();

    write_window(3'd4);
    push_sample(smf_pkg::sample_t'(32767), 0);
    push_sample(smf_pkg::sample_t'(-2), 1);
    push_sample(smf_pkg::sample_t'(-2), 0);
    drain_medians();

    // random phases, one window setting each
    for (p = 0; p < NUM_PHASES + 2; p++) begin
      write_window(p < NUM_PHASES ? phase_windows[p] : smf_pkg::cfg_t'($urandom_range(0, 7)));
      quiet = (p == 5);
      if (p == 2) hold_req = 1'b1;
      for (k = 0; k < PHASE_BEATS; k++) begin
        // sender pauses until the filter has emptied now and then
        if (k > 0 && $urandom_range(0, 39) == 0 && sb.pending() > 0) begin
          sample_valid <= 1'b0;
          while (sb.pending() > 0) @(posedge clk_i);
        end
        push_sample(rand_sample(), (p == 2 && k < 40) ? 0 : idle_len());
      end
      drain_medians();
      quiet = 1'b0;
    end

    sb.close_out();
    if (sb.failures == 0) begin
      $display("PASS sliding_median_filter");
    end else begin
      $display("FAIL sliding_median_filter");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/smf_pkg.sv
hdl/smf_history.sv
hdl/smf_rank.sv
hdl/sliding_median_filter.sv
tb/sliding_median_filter_tb.sv
